// ===== sv/stram_pkg.sv =====
`timescale 1ns / 1ps
// types, constants and helpers shared by the sparse table range argmax block
// no dependencies

package stram_pkg;

	localparam int MAX_LEN     = 1024;
	localparam int LEVELS      = 11;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = 10;
	localparam int LEN_W       = 11;
	localparam int LVL_W       = 4;
	localparam int TAB_AW      = LVL_W + IDX_W;
	localparam int TAB_DEPTH   = (LEVELS - 1) * MAX_LEN;
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	typedef logic [IDX_W-1:0]              idx_t;
	typedef logic [LEN_W-1:0]              len_t;
	typedef logic [LVL_W-1:0]              lvl_t;
	typedef logic [TAB_AW-1:0]             tab_addr_t;
	typedef logic signed [VALUE_WIDTH-1:0] value_t;

	// register select, taken from paddr[2]
	typedef enum logic {
		REG_ARRAY_LENGTH = 1'b0,
		REG_NONE         = 1'b1
	} reg_sel_t;

	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_BAD_RANGE = 2'd1,
		STATUS_NOT_READY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_QTAB,
		ST_QELEM,
		ST_BUILD
	} state_t;

	typedef struct packed {
		func_t  func;
		value_t value;
		idx_t   left;
		len_t   right;
	} req_t;

	typedef struct packed {
		idx_t    max_index;
		value_t  max_value;
		status_t status;
	} result_t;

	// position of the highest set bit
	function automatic lvl_t floor_log2(len_t v);
		lvl_t k;
		k = '0;
		for (int b = 0; b < LEN_W; b++) begin
			if (v[b]) begin
				k = lvl_t'(b);
			end
		end
		return k;
	endfunction

endpackage

// ===== sv/sparse_table_range_argmax.sv =====
`timescale 1ns / 1ps
// range maximum engine: element store, sparse table of argmax indices, build sequencer
// depends on stram_pkg

// Range-maximum block over up to 1024 signed 32-bit elements. Load requests
// (func 0) append values from index 0; the result echoes the position written.
// When the count reaches array_length (0 acts as 1, above 1024 acts as 1024) the
// block builds a sparse table of argmax indices, one level after another, one
// entry per cycle through a three-stage read/compare/write pipeline that drains
// between levels; no request is taken meanwhile. Query requests (func 1) pass
// through the two table reads, then the two element reads, then the compare, in
// the order set by the registered read ports of the two memories. Bad ranges,
// queries before the build and loads past the length answer through the result
// register without a query pass, with an error status and zero index and value.
// Ties go to the higher index. Writing array_length restarts the load; it must
// only be written while the block idles. The element store holds one write and
// two read ports, the table store likewise; level 0 of the table is the identity
// and is not stored. Neither store is cleared after reset.

module sparse_table_range_argmax (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               req_valid,
	output logic                               req_stall,
	input  stram_pkg::req_t                    req,
	// result channel
	output logic                               result_valid,
	input  logic                               result_stall,
	output stram_pkg::result_t                 result,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [stram_pkg::ADDR_W-1:0]       paddr,
	input  logic [stram_pkg::DATA_W-1:0]       pwdata,
	output logic [stram_pkg::DATA_W-1:0]       prdata,
	output logic                               pready
);

	// state and configuration
	stram_pkg::state_t state_q, state_d;
	stram_pkg::len_t   arr_len_q;
	stram_pkg::len_t   load_cnt_q;
	logic              built_q;
	stram_pkg::len_t   eff_len;
	logic              cfg_wr;

	// memories
	stram_pkg::value_t el_mem  [stram_pkg::MAX_LEN];
	stram_pkg::idx_t   tab_mem [stram_pkg::TAB_DEPTH];
	stram_pkg::value_t el_a_q, el_b_q;
	stram_pkg::idx_t   tab_a_q, tab_b_q;

	// build sequencer
	stram_pkg::lvl_t lvl_q;
	stram_pkg::idx_t bld_idx_q;
	logic            lvl_wait_q;

	// shared read pipeline
	logic            v_s1, v_s2;
	logic            id_s1;
	stram_pkg::idx_t ia_s1, ib_s1, widx_s1;
	stram_pkg::idx_t ia_s2, ib_s2, widx_s2;

	// request decode
	logic              accept;
	logic              is_query;
	logic              load_ok;
	logic              load_last;
	logic              range_bad;
	logic              query_go;
	stram_pkg::len_t   cnt_inc;
	stram_pkg::len_t   q_span;
	stram_pkg::lvl_t   q_lvl;
	stram_pkg::len_t   q_b_full;
	stram_pkg::idx_t   q_b_start;

	// build control
	logic                     in_build;
	logic                     build_issue;
	logic                     bld_last;
	logic                     level_ready;
	logic                     more_levels;
	logic                     build_finish;
	logic                     start_build;
	stram_pkg::len_t          lvl_limit;
	stram_pkg::lvl_t          lvl_nx;
	stram_pkg::idx_t          half;
	logic [stram_pkg::LEN_W:0] span_nx;

	// memory addressing
	stram_pkg::lvl_t     rd_level;
	stram_pkg::lvl_t     rd_row;
	stram_pkg::idx_t     rd_a_idx, rd_b_idx;
	stram_pkg::tab_addr_t tab_rd_a_addr, tab_rd_b_addr, tab_wr_addr;
	stram_pkg::idx_t     el_rd_a, el_rd_b;
	logic                a_wins;
	stram_pkg::idx_t     pick_idx;
	stram_pkg::value_t   pick_val;

	// immediate result of a load or a rejected request
	logic                imm_result;
	stram_pkg::result_t  imm_data;

	// ---------------------------------------------------------------- config
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite &&
		(stram_pkg::reg_sel_t'(paddr[2]) == stram_pkg::REG_ARRAY_LENGTH);

	always_comb begin
		prdata = '0;
		if (stram_pkg::reg_sel_t'(paddr[2]) == stram_pkg::REG_ARRAY_LENGTH) begin
			prdata = stram_pkg::DATA_W'(arr_len_q);
		end
	end

	// effective length: zero acts as one, capped at the store depth
	always_comb begin
		if (arr_len_q == '0) begin
			eff_len = stram_pkg::len_t'(1);
		end else if (arr_len_q > stram_pkg::len_t'(stram_pkg::MAX_LEN)) begin
			eff_len = stram_pkg::len_t'(stram_pkg::MAX_LEN);
		end else begin
			eff_len = arr_len_q;
		end
	end

	// ---------------------------------------------------------------- decode
	assign req_stall = (state_q != stram_pkg::ST_IDLE) || (result_valid && result_stall);
	assign accept    = req_valid && !req_stall;
	assign is_query  = (req.func == stram_pkg::FUNC_QUERY);

	assign cnt_inc   = load_cnt_q + stram_pkg::len_t'(1);
	assign load_ok   = !built_q && (load_cnt_q < eff_len);
	assign load_last = (cnt_inc == eff_len);

	assign range_bad = (stram_pkg::len_t'(req.left) >= req.right) || (req.right > eff_len);
	assign query_go  = built_q && !range_bad;

	// two overlapping windows of 2^q_lvl elements
	assign q_span    = req.right - stram_pkg::len_t'(req.left);
	assign q_lvl     = stram_pkg::floor_log2(q_span);
	assign q_b_full  = req.right - (stram_pkg::len_t'(1) << q_lvl);
	assign q_b_start = q_b_full[stram_pkg::IDX_W-1:0];

	assign start_build = accept && !is_query && load_ok && load_last &&
		(eff_len >= stram_pkg::len_t'(2));

	always_comb begin
		imm_result         = 1'b0;
		imm_data.max_index = '0;
		imm_data.max_value = '0;
		imm_data.status    = stram_pkg::STATUS_OK;
		if (accept) begin
			if (!is_query) begin
				imm_result = 1'b1;
				if (load_ok) begin
					imm_data.max_index = load_cnt_q[stram_pkg::IDX_W-1:0];
				end else begin
					imm_data.status = stram_pkg::STATUS_NOT_READY;
				end
			end else if (!built_q) begin
				imm_result      = 1'b1;
				imm_data.status = stram_pkg::STATUS_NOT_READY;
			end else if (range_bad) begin
				imm_result      = 1'b1;
				imm_data.status = stram_pkg::STATUS_BAD_RANGE;
			end
		end
	end

	// ---------------------------------------------------------------- build control
	assign in_build    = (state_q == stram_pkg::ST_BUILD);
	assign build_issue = in_build && !lvl_wait_q;
	assign lvl_limit   = eff_len - (stram_pkg::len_t'(1) << lvl_q);
	assign bld_last    = (stram_pkg::len_t'(bld_idx_q) == lvl_limit);
	assign half        = stram_pkg::idx_t'(1) << (lvl_q - stram_pkg::lvl_t'(1));
	assign lvl_nx      = lvl_q + stram_pkg::lvl_t'(1);
	assign span_nx     = (stram_pkg::LEN_W+1)'(1) << lvl_nx;
	// next level only once the previous one is fully written back
	assign level_ready = lvl_wait_q && !v_s1 && !v_s2;
	assign more_levels = (lvl_nx <= stram_pkg::lvl_t'(stram_pkg::LEVELS - 1)) &&
		(span_nx <= (stram_pkg::LEN_W+1)'(eff_len));
	assign build_finish = in_build && level_ready && !more_levels;

	// ---------------------------------------------------------------- state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stram_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			stram_pkg::ST_IDLE: begin
				if (accept && is_query && query_go) begin
					state_d = stram_pkg::ST_QTAB;
				end else if (start_build) begin
					state_d = stram_pkg::ST_BUILD;
				end
			end
			stram_pkg::ST_QTAB: begin
				state_d = stram_pkg::ST_QELEM;
			end
			stram_pkg::ST_QELEM: begin
				state_d = stram_pkg::ST_IDLE;
			end
			stram_pkg::ST_BUILD: begin
				if (build_finish) begin
					state_d = stram_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stram_pkg::ST_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arr_len_q  <= stram_pkg::len_t'(stram_pkg::MAX_LEN);
			load_cnt_q <= '0;
			built_q    <= 1'b0;
			lvl_q      <= stram_pkg::lvl_t'(1);
			bld_idx_q  <= '0;
			lvl_wait_q <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
		end else begin
			v_s1 <= build_issue;
			v_s2 <= v_s1;
			if (cfg_wr) begin
				arr_len_q  <= pwdata[stram_pkg::LEN_W-1:0];
				load_cnt_q <= '0;
				built_q    <= 1'b0;
			end else begin
				if (accept && !is_query && load_ok) begin
					load_cnt_q <= cnt_inc;
					// a single element needs no table beyond the identity level
					if (load_last && !start_build) begin
						built_q <= 1'b1;
					end
				end
				if (build_finish) begin
					built_q <= 1'b1;
				end
			end
			if (start_build) begin
				lvl_q      <= stram_pkg::lvl_t'(1);
				bld_idx_q  <= '0;
				lvl_wait_q <= 1'b0;
			end else if (build_issue) begin
				if (bld_last) begin
					lvl_wait_q <= 1'b1;
				end else begin
					bld_idx_q <= bld_idx_q + stram_pkg::idx_t'(1);
				end
			end else if (in_build && level_ready && more_levels) begin
				lvl_q      <= lvl_nx;
				bld_idx_q  <= '0;
				lvl_wait_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- table store
	// row r holds level r+1; a level-0 read falls back to the index itself
	assign rd_level = in_build ? (lvl_q - stram_pkg::lvl_t'(1)) : q_lvl;
	assign rd_row   = (rd_level == '0) ? '0 : (rd_level - stram_pkg::lvl_t'(1));
	assign rd_a_idx = in_build ? bld_idx_q : req.left;
	assign rd_b_idx = in_build ? (bld_idx_q + half) : q_b_start;

	assign tab_rd_a_addr = {rd_row, rd_a_idx};
	assign tab_rd_b_addr = {rd_row, rd_b_idx};
	assign tab_wr_addr   = {lvl_q - stram_pkg::lvl_t'(1), widx_s2};

	always_ff @(posedge clk) begin
		tab_a_q <= tab_mem[tab_rd_a_addr];
		tab_b_q <= tab_mem[tab_rd_b_addr];
		if (v_s2) begin
			tab_mem[tab_wr_addr] <= pick_idx;
		end
	end

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk) begin
		if (build_issue) begin
			id_s1   <= (lvl_q == stram_pkg::lvl_t'(1));
			ia_s1   <= bld_idx_q;
			ib_s1   <= bld_idx_q + half;
			widx_s1 <= bld_idx_q;
		end else if (accept && is_query) begin
			id_s1   <= (q_lvl == '0);
			ia_s1   <= req.left;
			ib_s1   <= q_b_start;
			widx_s1 <= req.left;
		end
	end

	// ---------------------------------------------------------------- element store
	assign el_rd_a = id_s1 ? ia_s1 : tab_a_q;
	assign el_rd_b = id_s1 ? ib_s1 : tab_b_q;

	always_ff @(posedge clk) begin
		el_a_q <= el_mem[el_rd_a];
		el_b_q <= el_mem[el_rd_b];
		if (accept && !is_query && load_ok) begin
			el_mem[load_cnt_q[stram_pkg::IDX_W-1:0]] <= req.value;
		end
	end

	// ---------------------------------------------------------------- stage 2
	always_ff @(posedge clk) begin
		ia_s2   <= el_rd_a;
		ib_s2   <= el_rd_b;
		widx_s2 <= widx_s1;
	end

	// strictly greater keeps the left candidate, ties go to the right one
	assign a_wins   = (el_a_q > el_b_q);
	assign pick_idx = a_wins ? ia_s2 : ib_s2;
	assign pick_val = a_wins ? el_a_q : el_b_q;

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (imm_result || (state_q == stram_pkg::ST_QELEM)) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (imm_result) begin
			result <= imm_data;
		end else if (state_q == stram_pkg::ST_QELEM) begin
			result.max_index <= pick_idx;
			result.max_value <= pick_val;
			result.status    <= stram_pkg::STATUS_OK;
		end
	end

`ifndef SYNTHESIS
	// a finishing query always finds the result register free
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stram_pkg::ST_QELEM) |-> !result_valid)
		else $error("query result would overwrite a pending result");

	// build pipeline only carries entries while building
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> (state_q == stram_pkg::ST_BUILD))
		else $error("build pipeline active outside build");

	// load count never runs past the effective length
	assert property (@(posedge clk) disable iff (!arst_n)
		load_cnt_q <= eff_len)
		else $error("load count beyond array length");

	// the built flag only drops through a length write
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(built_q) |-> $past(cfg_wr))
		else $error("table lost without a length write");

	// build levels stay inside the stored rows
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == stram_pkg::ST_BUILD) |->
		(lvl_q >= stram_pkg::lvl_t'(1)) &&
		(lvl_q <= stram_pkg::lvl_t'(stram_pkg::LEVELS - 1)))
		else $error("build level out of range");
`endif

endmodule
